FILE: hw/rtl/palette_channel_fade_engine_unit_macros.svh
// Assertion macros for the palette channel fade engine.
`ifndef PALETTE_CHANNEL_FADE_ENGINE_UNIT_MACROS_SVH
`define PALETTE_CHANNEL_FADE_ENGINE_UNIT_MACROS_SVH

// ante implies cons in the same cycle
`define PCFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcfe: same-cycle check failed");

// ante implies cons in the following cycle
`define PCFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcfe: next-cycle check failed");

`endif

FILE: hw/rtl/pcfe_pkg.sv
// Types, constants and codes shared by the fade engine modules.
package pcfe_pkg;

    localparam int C_NUM_CHANNELS = 8;
    localparam int C_CHAN_W       = 3;
    localparam int C_CHAN_SLOTS   = 2 ** C_CHAN_W;
    localparam int C_COLOR_W      = 15;
    localparam int C_COMP_W       = 5;
    localparam int C_GREEN_LSB    = 5;
    localparam int C_BLUE_LSB     = 10;
    localparam int C_FRAME_W      = 16;
    localparam int C_FRAC_W       = 17;
    localparam int C_QUO_W        = 2 * C_FRAME_W;
    localparam int C_DIV_STEPS    = C_QUO_W;
    localparam int C_DIV_CNT_W    = $clog2(C_DIV_STEPS);
    localparam int C_SUM_W        = 22;

    localparam logic [C_FRAC_W-1:0] C_ONE_FIX = 17'h10000;

    localparam logic C_OP_START = 1'b0;
    localparam logic C_OP_TICK  = 1'b1;

    localparam logic [1:0] C_COMP_RED   = 2'd0;
    localparam logic [1:0] C_COMP_GREEN = 2'd1;
    localparam logic [1:0] C_COMP_BLUE  = 2'd2;

    typedef struct packed {
        logic                 operation;
        logic [C_CHAN_W-1:0]  channel;
        logic [C_COLOR_W-1:0] from_color;
        logic [C_COLOR_W-1:0] to_color;
        logic [C_FRAME_W-1:0] frame_total;
    } t_in_item;

    typedef struct packed {
        logic [C_CHAN_W-1:0]  out_channel;
        logic [C_COLOR_W-1:0] out_color;
        logic                 finished;
        logic                 last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_FRAC,
        ST_MIX,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                load_start;
        logic                div_init;
        logic                div_step;
        logic                frac_load;
        logic                mix_en;
        logic [1:0]          comp;
        logic                emit;
        logic [C_CHAN_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic instant;
        logic more_after;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/palette_channel_fade_engine_unit.sv
// Top level of the palette channel fade engine: sequencer plus datapath.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): a start transfer loads
// one channel's colors and frame count. A tick transfer visits the eight
// channel slots in ascending order and yields one result transfer per active
// channel, the final one flagged last.
// Output channel (o_out_valid / i_out_stall / o_out_data): one result register.
// Tick steps: a scan step per slot visited; for a channel with a frame count
// of 0 or 1 the hand-off follows its scan; a fading channel adds 32 restoring
// divide steps for the fraction, a cap step and 3 component mix steps before
// its hand-off step. Scanning stops after the last active channel.
// o_in_stall is high from tick acceptance until the last result is in the
// output register; a new transfer is taken while that result still waits.
// A stalled receiver holds the engine in its hand-off step until the result
// register frees up.
// Reset (i_rst_n low, synchronous) clears all active flags and the output
// valid; channel colors and counts are loaded by start transfers.
`include "palette_channel_fade_engine_unit_macros.svh"

module palette_channel_fade_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pcfe_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pcfe_pkg::t_out_item o_out_data
);

    pcfe_pkg::t_cmd w_cmd;
    pcfe_pkg::t_sts w_sts;

    pcfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.operation),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    pcfe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a result is only loaded when the output register can take it
    `PCFE_ASSERT_SAME(a_emit_free, i_clk, i_rst_n, w_cmd.emit, w_sts.out_free)
    // only active channels produce results
    `PCFE_ASSERT_SAME(a_emit_active, i_clk, i_rst_n, w_cmd.emit, w_sts.active)
    // the result flagged last returns the engine to accepting input
    `PCFE_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, w_cmd.emit && !w_sts.more_after,
        !o_in_stall && o_out_valid && o_out_data.last)
    // a loaded result appears at the output next cycle
    `PCFE_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, w_cmd.emit, o_out_valid)

endmodule

FILE: hw/rtl/pcfe_ctrl.sv
// Sequencer: channel scan, divide steps, component mix and result hand-off.
module pcfe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_op,
    input  pcfe_pkg::t_sts  i_sts,
    output pcfe_pkg::t_cmd  o_cmd,
    output logic            o_in_stall
);

    localparam logic [pcfe_pkg::C_CHAN_W-1:0] C_LAST_SLOT =
        pcfe_pkg::C_CHAN_W'(pcfe_pkg::C_CHAN_SLOTS - 1);
    localparam logic [pcfe_pkg::C_DIV_CNT_W-1:0] C_LAST_STEP =
        pcfe_pkg::C_DIV_CNT_W'(pcfe_pkg::C_DIV_STEPS - 1);

    pcfe_pkg::t_state                   r_state, n_state;
    logic [pcfe_pkg::C_CHAN_W-1:0]      r_idx, n_idx;
    logic [pcfe_pkg::C_DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [1:0]                         r_comp, n_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcfe_pkg::ST_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_comp  <= pcfe_pkg::C_COMP_RED;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_comp     = r_comp;
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_cmd.comp = r_comp;
        o_in_stall = 1'b1;
        unique case (r_state)
            pcfe_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_in_op == pcfe_pkg::C_OP_START) begin
                        o_cmd.load_start = 1'b1;
                    end else begin
                        n_idx   = '0;
                        n_state = pcfe_pkg::ST_SCAN;
                    end
                end
            end
            pcfe_pkg::ST_SCAN: begin
                if (i_sts.active) begin
                    if (i_sts.instant) begin
                        n_state = pcfe_pkg::ST_EMIT;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_cnt          = '0;
                        n_state        = pcfe_pkg::ST_DIV;
                    end
                end else if (r_idx == C_LAST_SLOT) begin
                    n_state = pcfe_pkg::ST_IDLE;
                end else begin
                    n_idx = r_idx + pcfe_pkg::C_CHAN_W'(1);
                end
            end
            pcfe_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + pcfe_pkg::C_DIV_CNT_W'(1);
                if (r_cnt == C_LAST_STEP) begin
                    n_state = pcfe_pkg::ST_FRAC;
                end
            end
            pcfe_pkg::ST_FRAC: begin
                o_cmd.frac_load = 1'b1;
                n_comp          = pcfe_pkg::C_COMP_RED;
                n_state         = pcfe_pkg::ST_MIX;
            end
            pcfe_pkg::ST_MIX: begin
                o_cmd.mix_en = 1'b1;
                n_comp       = r_comp + 2'd1;
                if (r_comp == pcfe_pkg::C_COMP_BLUE) begin
                    n_state = pcfe_pkg::ST_EMIT;
                end
            end
            pcfe_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_sts.more_after || r_idx == C_LAST_SLOT) begin
                        n_state = pcfe_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + pcfe_pkg::C_CHAN_W'(1);
                        n_state = pcfe_pkg::ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = pcfe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/pcfe_dp.sv
// Datapath: channel state, restoring divider, component mixer, output register.
module pcfe_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcfe_pkg::t_in_item  i_in_data,
    input  pcfe_pkg::t_cmd      i_cmd,
    output pcfe_pkg::t_sts      o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output pcfe_pkg::t_out_item o_out_data
);

    localparam int C_N = pcfe_pkg::C_CHAN_SLOTS;

    logic [C_N-1:0]                  r_active;
    logic [pcfe_pkg::C_COLOR_W-1:0]  r_from  [C_N];
    logic [pcfe_pkg::C_COLOR_W-1:0]  r_to    [C_N];
    logic [pcfe_pkg::C_FRAME_W-1:0]  r_total [C_N];
    logic [pcfe_pkg::C_FRAME_W-1:0]  r_frame [C_N];

    logic [pcfe_pkg::C_FRAME_W-1:0]  r_rem;
    logic [pcfe_pkg::C_QUO_W-1:0]    r_quo;
    logic [pcfe_pkg::C_FRAC_W-1:0]   r_frac;
    logic [pcfe_pkg::C_COLOR_W-1:0]  r_mix;
    logic                            r_out_valid;
    pcfe_pkg::t_out_item             r_out_data;

    logic [pcfe_pkg::C_COLOR_W-1:0]  w_from, w_to;
    logic [pcfe_pkg::C_FRAME_W-1:0]  w_total, w_frame, w_next, w_divisor;
    logic [pcfe_pkg::C_FRAME_W:0]    w_trial, w_diff;
    logic                            w_ge;
    logic [C_N-1:0]                  w_above;
    logic                            w_start_ok;
    logic                            w_done;
    logic [pcfe_pkg::C_COLOR_W-1:0]  w_from_sh, w_to_sh;
    logic [pcfe_pkg::C_COMP_W-1:0]   w_a, w_b, w_res;
    logic [pcfe_pkg::C_FRAC_W-1:0]   w_inv;
    logic [pcfe_pkg::C_SUM_W-1:0]    w_sum;

    assign w_from    = r_from[i_cmd.idx];
    assign w_to      = r_to[i_cmd.idx];
    assign w_total   = r_total[i_cmd.idx];
    assign w_frame   = r_frame[i_cmd.idx];
    assign w_next    = w_frame + pcfe_pkg::C_FRAME_W'(1);
    assign w_done    = (w_next >= w_total);
    assign w_divisor = w_total - pcfe_pkg::C_FRAME_W'(1);

    // one quotient bit per step; remainder always stays below the divisor
    assign w_trial = {r_rem, r_quo[pcfe_pkg::C_QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, w_divisor});
    assign w_diff  = w_trial - {1'b0, w_divisor};

    assign w_above    = r_active >> i_cmd.idx;
    assign w_start_ok = (32'(i_in_data.channel) < pcfe_pkg::C_NUM_CHANNELS);

    always_comb begin
        case (i_cmd.comp)
            pcfe_pkg::C_COMP_GREEN: begin
                w_from_sh = w_from >> pcfe_pkg::C_GREEN_LSB;
                w_to_sh   = w_to >> pcfe_pkg::C_GREEN_LSB;
            end
            pcfe_pkg::C_COMP_BLUE: begin
                w_from_sh = w_from >> pcfe_pkg::C_BLUE_LSB;
                w_to_sh   = w_to >> pcfe_pkg::C_BLUE_LSB;
            end
            default: begin
                w_from_sh = w_from;
                w_to_sh   = w_to;
            end
        endcase
    end

    assign w_a   = w_from_sh[pcfe_pkg::C_COMP_W-1:0];
    assign w_b   = w_to_sh[pcfe_pkg::C_COMP_W-1:0];
    assign w_inv = pcfe_pkg::C_ONE_FIX - r_frac;
    assign w_sum = pcfe_pkg::C_SUM_W'(w_a) * pcfe_pkg::C_SUM_W'(w_inv)
                 + pcfe_pkg::C_SUM_W'(w_b) * pcfe_pkg::C_SUM_W'(r_frac);
    assign w_res = w_sum[pcfe_pkg::C_FRAME_W +: pcfe_pkg::C_COMP_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_start && w_start_ok) begin
                r_active[i_in_data.channel] <= 1'b1;
            end else if (i_cmd.emit && w_done) begin
                r_active[i_cmd.idx] <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start && w_start_ok) begin
            r_from[i_in_data.channel]  <= i_in_data.from_color;
            r_to[i_in_data.channel]    <= i_in_data.to_color;
            r_total[i_in_data.channel] <= i_in_data.frame_total;
            r_frame[i_in_data.channel] <= '0;
        end else if (i_cmd.emit) begin
            r_frame[i_cmd.idx] <= w_next;
        end

        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= {w_frame, {pcfe_pkg::C_FRAME_W{1'b0}}};
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[pcfe_pkg::C_FRAME_W-1:0]
                          : w_trial[pcfe_pkg::C_FRAME_W-1:0];
            r_quo <= {r_quo[pcfe_pkg::C_QUO_W-2:0], w_ge};
        end

        if (i_cmd.frac_load) begin
            r_frac <= (r_quo > pcfe_pkg::C_QUO_W'(pcfe_pkg::C_ONE_FIX))
                    ? pcfe_pkg::C_ONE_FIX : r_quo[pcfe_pkg::C_FRAC_W-1:0];
        end

        if (i_cmd.mix_en) begin
            case (i_cmd.comp)
                pcfe_pkg::C_COMP_GREEN:
                    r_mix[pcfe_pkg::C_GREEN_LSB +: pcfe_pkg::C_COMP_W] <= w_res;
                pcfe_pkg::C_COMP_BLUE:
                    r_mix[pcfe_pkg::C_BLUE_LSB +: pcfe_pkg::C_COMP_W] <= w_res;
                default:
                    r_mix[0 +: pcfe_pkg::C_COMP_W] <= w_res;
            endcase
        end

        if (i_cmd.emit) begin
            r_out_data.out_channel <= i_cmd.idx;
            r_out_data.out_color   <= (w_total > 16'd1) ? r_mix : w_to;
            r_out_data.finished    <= w_done;
            r_out_data.last        <= ~|w_above[C_N-1:1];
        end
    end

    assign o_sts.active     = w_above[0];
    assign o_sts.instant    = (w_total <= 16'd1);
    assign o_sts.more_after = |w_above[C_N-1:1];
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
